### src/lsbd_pkg.sv
// ---------------------------------------------------------------------------
// lsbd_pkg
// Shared types and constants of the lidar sector bump detector: register
// indexes, field widths, side codes and the sector bounds bundle.
// ---------------------------------------------------------------------------
package lsbd_pkg;

   // Fixed field widths
   localparam int NEAR_W      = 16;
   localparam int SCAN_W      = 12;
   localparam int QTR_W       = SCAN_W - 2;
   localparam int THIRD_W     = QTR_W - 1;
   localparam int SIDE_W      = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_LIMIT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCAN_POINTS = 1'b1;

   // Register reset values and the bounds that follow from them
   localparam int NEAR_RESET  = 300;
   localparam int SCAN_RESET  = 360;
   localparam int QTR_RESET   = SCAN_RESET / 4;
   localparam int THIRD_RESET = QTR_RESET / 3;

   // Divide by three: floor(q * 683 / 2048) is exact for every 10-bit q
   localparam int                 THIRD_SHIFT = 11;
   localparam int                 PROD_W      = 2 * QTR_W;
   localparam logic [QTR_W-1:0]   THIRD_MUL   = 10'd683;

   // Side codes
   localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_CENTER = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd2;

   // Event kinds
   localparam logic CONTACT_RELEASED = 1'b0;
   localparam logic CONTACT_PRESSED  = 1'b1;

   // Sector bounds and near limit, held by the register block
   typedef struct packed {
      logic [NEAR_W-1:0]  near_limit;
      logic [QTR_W-1:0]   quarter;
      logic [THIRD_W-1:0] third;
      logic [SCAN_W-1:0]  n_minus_q;
      logic [SCAN_W-1:0]  n_minus_c;
   } bounds_type;

   // One sample after the input stage
   typedef struct packed {
      logic near;
      logic scan_end;
   } item_type;

endpackage

### src/lsbd_req_if.sv
// ---------------------------------------------------------------------------
// lsbd_req_if
// Sample channel: one range sample and its last-of-scan flag per transaction.
// ---------------------------------------------------------------------------
interface lsbd_req_if #(
   parameter int RANGE_BITS = 16
) ();
   logic                  valid;
   logic                  ready;
   logic [RANGE_BITS-1:0] range_mm;
   logic                  scan_end;

   modport source (output valid, output range_mm, output scan_end, input ready);
   modport sink   (input valid, input range_mm, input scan_end, output ready);
endinterface

### src/lsbd_rsp_if.sv
// ---------------------------------------------------------------------------
// lsbd_rsp_if
// Event channel: one pressed or released event with its side per transaction.
// ---------------------------------------------------------------------------
interface lsbd_rsp_if
   import lsbd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              contact;
   logic [SIDE_W-1:0] side;

   modport source (output valid, output contact, output side, input ready);
   modport sink   (input valid, input contact, input side, output ready);
endinterface

### src/lsbd_csr.sv
// ---------------------------------------------------------------------------
// lsbd_csr
// Register block: holds the near limit and, on a scan length write, the
// quarter, third-of-quarter and right sector bounds derived from it.
// ---------------------------------------------------------------------------
module lsbd_csr
   import lsbd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output bounds_type             bounds
);

   bounds_type          bounds_ff, bounds_in;
   logic [SCAN_W-1:0]   scan_n;
   logic [QTR_W-1:0]    quarter;
   logic [PROD_W-1:0]   third_prod;
   logic [THIRD_W-1:0]  third;

   // Derive sector bounds from the written scan length
   assign scan_n     = csr_wdata[SCAN_W-1:0];
   assign quarter    = scan_n[SCAN_W-1:2];
   assign third_prod = PROD_W'(quarter) * PROD_W'(THIRD_MUL);
   assign third      = third_prod[THIRD_SHIFT +: THIRD_W];

   always_comb begin
      bounds_in = bounds_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NEAR_LIMIT: begin
               bounds_in.near_limit = csr_wdata[NEAR_W-1:0];
            end
            CSR_SCAN_POINTS: begin
               bounds_in.quarter   = quarter;
               bounds_in.third     = third;
               bounds_in.n_minus_q = scan_n - SCAN_W'(quarter);
               bounds_in.n_minus_c = scan_n - SCAN_W'(third);
            end
            default: begin
               bounds_in = bounds_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff.near_limit <= NEAR_W'(NEAR_RESET);
         bounds_ff.quarter    <= QTR_W'(QTR_RESET);
         bounds_ff.third      <= THIRD_W'(THIRD_RESET);
         bounds_ff.n_minus_q  <= SCAN_W'(SCAN_RESET - QTR_RESET);
         bounds_ff.n_minus_c  <= SCAN_W'(SCAN_RESET - THIRD_RESET);
      end else begin
         bounds_ff <= bounds_in;
      end
   end

   assign bounds = bounds_ff;

endmodule

### src/lsbd_tracker.sv
// ---------------------------------------------------------------------------
// lsbd_tracker
// Scan tracker: counts samples, latches the first near edge-sector hit,
// decides the event at scan end and holds it in the result register.
// ---------------------------------------------------------------------------
module lsbd_tracker
   import lsbd_pkg::*;
#(
   parameter int MAX_POINTS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  bounds_type  bounds,
   input  item_type    item,
   input  logic        adv,
   output logic        out_free,
   lsbd_rsp_if.source  rsp_chan
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CMP_W = (IDX_W > SCAN_W) ? IDX_W : SCAN_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_POINTS - 1);

   logic              is_pressed_ff, is_pressed_in;
   logic [SIDE_W-1:0] last_side_ff, last_side_in;
   logic [IDX_W-1:0]  sample_index_ff, sample_index_in;
   logic              hit_seen_ff, hit_seen_in;
   logic [IDX_W-1:0]  hit_index_ff, hit_index_in;
   logic              any_near_ff, any_near_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              contact_ff, contact_in;
   logic [SIDE_W-1:0] side_ff, side_in;

   logic [CMP_W-1:0]  idx_cmp;
   logic [CMP_W-1:0]  pos_cmp;
   logic [CMP_W-1:0]  q_cmp, c_cmp, nmq_cmp, nmc_cmp;
   logic              in_edge, latch_hit;
   logic              hit_seen_now, any_near_now;
   logic [IDX_W-1:0]  hit_index_now;
   logic [SIDE_W-1:0] hit_side;
   logic              fire_press, fire_release;

   assign q_cmp   = CMP_W'(bounds.quarter);
   assign c_cmp   = CMP_W'(bounds.third);
   assign nmq_cmp = CMP_W'(bounds.n_minus_q);
   assign nmc_cmp = CMP_W'(bounds.n_minus_c);

   // Latch the first near sample in an edge sector while released
   assign idx_cmp   = CMP_W'(sample_index_ff);
   assign in_edge   = (idx_cmp < q_cmp) || (idx_cmp > nmq_cmp);
   assign latch_hit = item.near && !is_pressed_ff && !hit_seen_ff && in_edge;

   assign hit_seen_now  = hit_seen_ff | latch_hit;
   assign hit_index_now = latch_hit ? sample_index_ff : hit_index_ff;
   assign any_near_now  = any_near_ff | item.near;

   // Classify the side of the latched hit
   assign pos_cmp = CMP_W'(hit_index_now);
   always_comb begin
      if ((pos_cmp > c_cmp) && (pos_cmp < q_cmp)) begin
         hit_side = SIDE_LEFT;
      end else if ((pos_cmp > nmq_cmp) && (pos_cmp < nmc_cmp)) begin
         hit_side = SIDE_RIGHT;
      end else begin
         hit_side = SIDE_CENTER;
      end
   end

   assign fire_press   = item.scan_end && !is_pressed_ff && hit_seen_now;
   assign fire_release = item.scan_end && is_pressed_ff && !any_near_now;

   // The result register can take a new transaction when empty or draining
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Advance scan state and result register
   always_comb begin
      is_pressed_in   = is_pressed_ff;
      last_side_in    = last_side_ff;
      sample_index_in = sample_index_ff;
      hit_seen_in     = hit_seen_ff;
      hit_index_in    = hit_index_ff;
      any_near_in     = any_near_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      contact_in      = contact_ff;
      side_in         = side_ff;
      if (adv) begin
         rsp_valid_in = fire_press || fire_release;
         hit_index_in = hit_index_now;
         if (item.scan_end) begin
            sample_index_in = '0;
            hit_seen_in     = 1'b0;
            any_near_in     = 1'b0;
            if (fire_press) begin
               is_pressed_in = 1'b1;
               last_side_in  = hit_side;
               contact_in    = CONTACT_PRESSED;
               side_in       = hit_side;
            end else if (fire_release) begin
               is_pressed_in = 1'b0;
               contact_in    = CONTACT_RELEASED;
               side_in       = last_side_ff;
            end
         end else begin
            hit_seen_in = hit_seen_now;
            any_near_in = any_near_now;
            if (sample_index_ff != IDX_LAST) begin
               sample_index_in = sample_index_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_pressed_ff   <= 1'b0;
         last_side_ff    <= SIDE_LEFT;
         sample_index_ff <= '0;
         hit_seen_ff     <= 1'b0;
         hit_index_ff    <= '0;
         any_near_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         is_pressed_ff   <= is_pressed_in;
         last_side_ff    <= last_side_in;
         sample_index_ff <= sample_index_in;
         hit_seen_ff     <= hit_seen_in;
         hit_index_ff    <= hit_index_in;
         any_near_ff     <= any_near_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      contact_ff <= contact_in;
      side_ff    <= side_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.contact = contact_ff;
   assign rsp_chan.side    = side_ff;

`ifndef SYNTHESIS
   // An event leaves the press state equal to its kind
   a_event_sets_state: assert property (@(posedge clock) disable iff (reset)
      adv && (fire_press || fire_release) |=> is_pressed_ff == rsp_chan.contact)
      else $error("event kind does not match new press state");

   // Scan end clears the per-scan state
   a_scan_end_clears: assert property (@(posedge clock) disable iff (reset)
      adv && item.scan_end |=> sample_index_ff == '0 && !hit_seen_ff && !any_near_ff)
      else $error("per-scan state not cleared at scan end");

   // A hit is only latched while released
   a_hit_only_released: assert property (@(posedge clock) disable iff (reset)
      hit_seen_ff |-> !is_pressed_ff)
      else $error("hit latched while pressed");

   // Reported side is a defined code
   a_side_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (side_ff == SIDE_LEFT || side_ff == SIDE_CENTER
                        || side_ff == SIDE_RIGHT))
      else $error("undefined side code");
`endif

endmodule

### src/lidar_sector_bump_detector_unit.sv
// ---------------------------------------------------------------------------
// lidar_sector_bump_detector_unit
// Lidar sector bump detector: turns a stream of range samples into pressed
// and released bump events with the side of the contact.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one range sample (millimetres) per transaction, with
//   scan_end high on the last sample of a scan. rsp_chan carries at most one
//   event per scan, produced only by a scan_end sample: contact 1 with the
//   side of the first near edge-sector sample, or contact 0 when a pressed
//   detector sees a scan with no near sample at all.
//   csr_we/csr_index/csr_wdata write the near limit (index 0) and the scan
//   length (index 1); write them only while no sample is in flight.
//   An event passes from its accepted scan_end sample through the input
//   register, then the result register, to rsp_chan.
//   Throughput: one sample per cycle while rsp_chan does not stall, set
//   by the scan tracker between the input register and the result register.
//   Reset clears the press state, the scan counters and both registers, and
//   restores the near limit to 300 mm and the scan length to 360 samples.
//   When rsp_chan stalls, the pending event holds and the input register
//   fills; req_chan.ready then drops until the event is taken.
// ---------------------------------------------------------------------------
module lidar_sector_bump_detector_unit
   import lsbd_pkg::*;
#(
   parameter int MAX_POINTS = 2048,
   parameter int RANGE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   lsbd_req_if.sink               req_chan,
   lsbd_rsp_if.source             rsp_chan
);

   localparam int CMP_RW = (RANGE_BITS > NEAR_W) ? RANGE_BITS : NEAR_W;

   bounds_type        bounds;
   logic              s1_valid_ff, s1_valid_in;
   item_type          s1_item_ff, s1_item_in;
   logic              out_free, adv, take;
   logic [CMP_RW-1:0] range_ext, limit_ext;

   lsbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .bounds    (bounds)
   );

   // Input register handshake
   assign adv            = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || adv;
   assign take           = req_chan.valid && req_chan.ready;

   // Compare the sample against the near limit on the way in
   assign range_ext = CMP_RW'(req_chan.range_mm);
   assign limit_ext = CMP_RW'(bounds.near_limit);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (take) begin
         s1_valid_in         = 1'b1;
         s1_item_in.near     = range_ext < limit_ext;
         s1_item_in.scan_end = req_chan.scan_end;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
   end

   lsbd_tracker #(
      .MAX_POINTS (MAX_POINTS)
   ) u_tracker (
      .clock    (clock),
      .reset    (reset),
      .bounds   (bounds),
      .item     (s1_item_ff),
      .adv      (adv),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

### sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench of the lidar sector bump detector. Range samples stream in scan
// by scan, while a scan tracker kept in the testbench predicts the pressed
// and released events. Each event taken from the result channel is checked
// field by field against the oldest prediction. Register settings change
// between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsbd_pkg::*;

   localparam realtime CLK_PERIOD    = 2.0ns;
   localparam int      MAX_POINTS    = 2048;
   localparam int      RANGE_BITS    = 16;
   localparam int      SETTLE_CYCLES = 6;
   localparam int      CYCLE_LIMIT   = 300000;
   localparam int      STALL_PCT     = 13;

   typedef struct packed {
      logic [RANGE_BITS-1:0] range_mm;
      logic                  last;
   } sample_type;

   typedef struct packed {
      logic              contact;
      logic [SIDE_W-1:0] side;
   } bump_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lsbd_req_if #(.RANGE_BITS(RANGE_BITS)) req_chan ();
   lsbd_rsp_if                            rsp_chan ();

   lidar_sector_bump_detector_unit #(
      .MAX_POINTS (MAX_POINTS),
      .RANGE_BITS (RANGE_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // Samples waiting to be sent and events waiting to arrive
   sample_type pending_samples[$];
   bump_type   expected_events[$];
   int         samples_queued = 0;
   int         samples_taken  = 0;
   int         mismatches     = 0;
   int         cycle_count    = 0;
   bit         steady_flow    = 1'b0;

   // Register copies and scan tracker state
   logic [NEAR_W-1:0] cfg_near_limit = NEAR_W'(NEAR_RESET);
   logic [SCAN_W-1:0] cfg_scan_len   = SCAN_W'(SCAN_RESET);
   bit                press_state = 1'b0;
   logic [SIDE_W-1:0] press_side  = SIDE_LEFT;
   int                scan_pos    = 0;
   bit                edge_hit    = 1'b0;
   int                edge_pos    = 0;
   bit                scan_near   = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // -------------------------------------------------------------------------
   // Scan tracker
   // -------------------------------------------------------------------------

   // Side of a contact from its sample position and the scan length
   function automatic logic [SIDE_W-1:0] side_of(int pos, int n);
      int q;
      int c;
      q = n / 4;
      c = q / 3;
      if (pos > c && pos < q)
         return SIDE_LEFT;
      if (pos > n - q && pos < n - c)
         return SIDE_RIGHT;
      return SIDE_CENTER;
   endfunction

   // Advance the tracker by one accepted sample, queue any event it causes
   task automatic track_sample(logic [RANGE_BITS-1:0] range_mm, logic last);
      int       n;
      int       q;
      bump_type ev;
      n = cfg_scan_len;
      q = n / 4;
      if (range_mm < cfg_near_limit) begin
         scan_near = 1'b1;
         if (!press_state && !edge_hit && (scan_pos < q || scan_pos > n - q)) begin
            edge_hit = 1'b1;
            edge_pos = scan_pos;
         end
      end
      if (last) begin
         if (press_state) begin
            if (!scan_near) begin
               press_state = 1'b0;
               ev.contact  = CONTACT_RELEASED;
               ev.side     = press_side;
               expected_events.push_back(ev);
            end
         end else if (edge_hit) begin
            press_state = 1'b1;
            press_side  = side_of(edge_pos, n);
            ev.contact  = CONTACT_PRESSED;
            ev.side     = press_side;
            expected_events.push_back(ev);
         end
         scan_pos  = 0;
         edge_hit  = 1'b0;
         scan_near = 1'b0;
      end else if (scan_pos < MAX_POINTS - 1) begin
         scan_pos++;
      end
   endtask

   // -------------------------------------------------------------------------
   // Driver and monitor
   // -------------------------------------------------------------------------

   function automatic bit roll_stall();
      return !steady_flow && ($urandom_range(0, 99) < STALL_PCT);
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   // Send pending samples, track each transaction as it is taken
   always @(posedge clock) begin
      sample_type s;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            track_sample(req_chan.range_mm, req_chan.scan_end);
            samples_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_samples.size() > 0 && !roll_stall()) begin
               s = pending_samples.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.range_mm <= s.range_mm;
               req_chan.scan_end <= s.last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Take events and compare them with the oldest prediction
   always @(posedge clock) begin
      bump_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("unexpected event contact=%0d side=%0d",
                                         rsp_chan.contact, rsp_chan.side));
            end else begin
               want = expected_events.pop_front();
               if (rsp_chan.contact !== want.contact)
                  report_mismatch($sformatf("contact %0d, want %0d",
                                            rsp_chan.contact, want.contact));
               if (rsp_chan.side !== want.side)
                  report_mismatch($sformatf("side %0d, want %0d",
                                            rsp_chan.side, want.side));
            end
         end
         rsp_chan.ready <= !roll_stall();
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   task automatic push_sample(logic [RANGE_BITS-1:0] range_mm, logic last);
      sample_type s;
      s.range_mm = range_mm;
      s.last     = last;
      pending_samples.push_back(s);
      samples_queued++;
   endtask

   function automatic logic [RANGE_BITS-1:0] far_value();
      int lim;
      lim = cfg_near_limit;
      if ($urandom_range(0, 9) == 0)
         return '1;
      return RANGE_BITS'($urandom_range(lim, 65535));
   endfunction

   function automatic logic [RANGE_BITS-1:0] near_value();
      int lim;
      lim = cfg_near_limit;
      if (lim == 0)
         return far_value();
      if ($urandom_range(0, 9) == 0)
         return '0;
      return RANGE_BITS'($urandom_range(0, lim - 1));
   endfunction

   // One scan: near at hit_pos and at random with near_pct percent
   task automatic push_scan(int len, int near_pct, int hit_pos);
      bit near;
      for (int i = 0; i < len; i++) begin
         near = (i == hit_pos) || ($urandom_range(0, 99) < near_pct);
         push_sample(near ? near_value() : far_value(), i == len - 1);
      end
   endtask

   // Mostly well-formed scans, some with a wrong length
   task automatic random_scan();
      int n;
      int roll;
      n    = cfg_scan_len;
      roll = $urandom_range(0, 99);
      if (roll < 35)
         push_scan(n, 0, -1);
      else if (roll < 70)
         push_scan(n, 0, $urandom_range(0, n - 1));
      else if (roll < 88)
         push_scan(n, $urandom_range(1, 30), -1);
      else
         push_scan($urandom_range(1, 2 * n + 2), $urandom_range(0, 20),
                   $urandom_range(0, 1) ? $urandom_range(0, 2 * n + 2) : -1);
   endtask

   // Wait until every sample is taken and every event has arrived
   task automatic settle();
      while (samples_taken != samples_queued || expected_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_NEAR_LIMIT)
         cfg_near_limit = value;
      else
         cfg_scan_len = value[SCAN_W-1:0];
   endtask

   task automatic set_config(int lim, int n);
      settle();
      csr_write(CSR_NEAR_LIMIT, CSR_DATA_W'(lim));
      csr_write(CSR_SCAN_POINTS, CSR_DATA_W'(n));
   endtask

   task automatic run_phase(int lim, int n, int budget);
      int start;
      set_config(lim, n);
      start = samples_queued;
      while (samples_queued - start < budget)
         random_scan();
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.range_mm = '0;
      req_chan.scan_end = 1'b0;
      rsp_chan.ready    = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_NEAR_LIMIT;
      csr_wdata         = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: one full scan pressed on the left, then release
      for (int i = 0; i < SCAN_RESET; i++)
         push_sample(i == 50 ? 16'd100 : far_value(), i == SCAN_RESET - 1);
      push_sample('1, 1'b1);

      // Directed scans at N = 12: edges below 3 and above 9
      set_config(300, 12);
      push_sample(16'd299, 1'b1);   // near at index 0: pressed center
      push_sample(16'd0, 1'b1);     // near while pressed: hold
      push_sample(16'd300, 1'b1);   // at the limit is not near: release
      push_sample('1, 1'b0);
      push_sample(16'd300, 1'b0);
      push_sample(16'd299, 1'b1);   // pressed left
      push_sample('1, 1'b1);
      for (int i = 0; i < 11; i++)  // mid-scan near ignored, pressed right
         push_sample(i == 5 ? 16'd0 : (i == 10 ? 16'd299 : 16'hFFFF), i == 10);
      push_sample('1, 1'b1);
      push_sample(16'd0, 1'b0);     // first edge hit wins
      push_sample(16'd100, 1'b1);
      push_sample('1, 1'b1);

      // Scan length below four: no left or right sector, edge sector only past N
      set_config(300, 3);
      for (int i = 0; i < 4; i++)
         push_sample(16'd0, i == 3);
      for (int i = 0; i < 5; i++)
         push_sample(i == 4 ? 16'd0 : 16'hFFFF, i == 4);
      push_sample('1, 1'b1);
      run_phase(300, 3, 40);

      // Scan length of MAX_POINTS, short scan judged against its wide sectors
      set_config(1000, 2048);
      push_scan(20, 10, 5);
      push_sample('1, 1'b1);

      // Random phases over a spread of settings
      run_phase(300, 16, 200);
      run_phase(0, 8, 100);
      run_phase(65535, 4, 100);
      set_config(1, 24);
      steady_flow = 1'b1;
      run_phase(1, 24, 150);
      settle();
      steady_flow = 1'b0;
      repeat (3)
         run_phase($urandom_range(0, 65535), $urandom_range(4, 64), 150);
      run_phase(65534, 5, 100);

      settle();
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### lidar_sector_bump_detector_unit.f
src/lsbd_pkg.sv
src/lsbd_req_if.sv
src/lsbd_rsp_if.sv
src/lsbd_csr.sv
src/lsbd_tracker.sv
src/lidar_sector_bump_detector_unit.sv
sim/tb.sv
